### sv/sdw_pkg.sv
package sdw_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W    = 32;
  localparam int TIMEOUT_W   = 8;
  localparam int TOLERANCE_W = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  // Percent scale used by the deviation band.
  localparam int PERCENT = 100;

  // Width of the band factors 100 + tol and 100 - tol, signed.
  localparam int FACTOR_W = 9;

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 1'b1;

  // Configuration reset values.
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = 8'd10;
  localparam logic [TOLERANCE_W-1:0] TOLERANCE_RESET = 7'd10;

  // Alarm codes.
  typedef enum logic [1:0] {
    ALARM_OFFLINE = 2'd0,
    ALARM_ABOVE   = 2'd1,
    ALARM_BELOW   = 2'd2
  } alarm_t;

  // Input item.
  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_t;

  // Result item.
  typedef struct packed {
    alarm_t                     alarm;
    logic signed [SAMPLE_W-1:0] reported_value;
  } out_t;

endpackage

### sv/sensor_deviation_watchdog_core.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_data  (sdw_pkg::in_t)
// out      output     out_valid/ out_stall out_data (sdw_pkg::out_t)
// cfg      input      cfg_write            cfg_index, cfg_data
//
// One item is taken per clock while in_stall is low; a result passes through the
// input register, the product register, then the output register to reach out.
// The rate is set by the running-sum update and one multiplier per band product.
// Reset clears all control state; window entries are not cleared, since an entry
// is read only after it has been written. A stalled output keeps its result while
// the earlier stages fill; in_stall rises once a tick waits.
module sensor_deviation_watchdog_core #(
  parameter int WINDOW_SIZE = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sdw_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sdw_pkg::out_t                      out_data,
  input  logic                               cfg_write,
  input  logic [sdw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sdw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SUM_W  = sdw_pkg::SAMPLE_W + $clog2(WINDOW_SIZE);
  localparam int N100_W = $clog2(WINDOW_SIZE * 100 + 1);

  logic [sdw_pkg::TIMEOUT_W-1:0]       timeout_ticks;
  logic [sdw_pkg::TOLERANCE_W-1:0]     tolerance_percent;

  logic                                a_valid;
  sdw_pkg::in_t                        a_item;
  logic                                a_is_sample;
  logic                                a_go;
  logic                                in_accept;
  logic                                sample_go;
  logic                                tick_go;

  logic                                b_valid;
  logic                                b_ok;
  logic                                b_go;
  logic                                c_ok;
  logic                                res_valid;
  sdw_pkg::out_t                       res;

  logic signed [sdw_pkg::SAMPLE_W-1:0] latest;
  logic [N100_W-1:0]                   n100;
  logic signed [SUM_W-1:0]             sum;
  logic                                empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks     <= sdw_pkg::TIMEOUT_RESET;
      tolerance_percent <= sdw_pkg::TOLERANCE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sdw_pkg::CFG_TIMEOUT: begin
          timeout_ticks <= cfg_data[sdw_pkg::TIMEOUT_W-1:0];
        end
        sdw_pkg::CFG_TOLERANCE: begin
          tolerance_percent <= cfg_data[sdw_pkg::TOLERANCE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control. Samples finish in the input stage; ticks need
  // room in the compare stage.
  assign c_ok        = !out_valid || !out_stall;
  assign b_go        = b_valid && c_ok;
  assign b_ok        = !b_valid || c_ok;
  assign a_is_sample = (a_item.kind == sdw_pkg::KIND_SAMPLE);
  assign a_go        = a_valid && (a_is_sample || b_ok);
  assign in_stall    = a_valid && !a_go;
  assign in_accept   = in_valid && !in_stall;
  assign sample_go   = a_go && a_is_sample;
  assign tick_go     = a_go && !a_is_sample;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_item <= in_data;
    end
  end

  sdw_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .sample_go    (sample_go),
    .sample_value (a_item.sample_value),
    .latest       (latest),
    .n100         (n100),
    .sum          (sum),
    .empty        (empty)
  );

  sdw_check #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_check (
    .clk               (clk),
    .rst               (rst),
    .sample_go         (sample_go),
    .tick_go           (tick_go),
    .timeout_ticks     (timeout_ticks),
    .tolerance_percent (tolerance_percent),
    .latest            (latest),
    .n100              (n100),
    .sum               (sum),
    .empty             (empty),
    .b_go              (b_go),
    .b_valid           (b_valid),
    .res_valid         (res_valid),
    .res               (res)
  );

  // Output register; holds its result until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && res_valid) begin
      out_data <= res;
    end
  end

endmodule

### sv/sdw_window.sv
module sdw_window #(
  parameter int WINDOW_SIZE = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       sample_go,
  input  logic signed [sdw_pkg::SAMPLE_W-1:0]        sample_value,
  output logic signed [sdw_pkg::SAMPLE_W-1:0]        latest,
  output logic [$clog2(WINDOW_SIZE*100+1)-1:0]       n100,
  output logic signed [sdw_pkg::SAMPLE_W+$clog2(WINDOW_SIZE)-1:0] sum,
  output logic                                       empty
);

  localparam int SLOT_W = $clog2(WINDOW_SIZE);
  localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W  = sdw_pkg::SAMPLE_W + SLOT_W;
  localparam int N100_W = $clog2(WINDOW_SIZE * 100 + 1);

  logic signed [sdw_pkg::SAMPLE_W-1:0] window_store [WINDOW_SIZE];
  logic signed [sdw_pkg::SAMPLE_W-1:0] old_sample;
  logic [SLOT_W-1:0]                   write_slot;
  logic [SLOT_W-1:0]                   write_slot_next;
  logic [FILL_W-1:0]                   fill_count;
  logic                                full;
  logic signed [SUM_W-1:0]             sum_next;

  assign full  = (fill_count == FILL_W'(WINDOW_SIZE));
  assign empty = (fill_count == '0);

  // Slot pointer advances and wraps on each sample transfer.
  always_comb begin
    write_slot_next = write_slot;
    if (sample_go) begin
      if (write_slot == SLOT_W'(WINDOW_SIZE - 1)) begin
        write_slot_next = '0;
      end else begin
        write_slot_next = write_slot + 1'b1;
      end
    end
  end

  // Running sum: add the new sample, drop the oldest once the window is full.
  always_comb begin
    sum_next = sum + SUM_W'(sample_value);
    if (full) begin
      sum_next = sum_next - SUM_W'(old_sample);
    end
  end

  // Window memory. The entry at the next write slot is prefetched every cycle,
  // so the oldest sample is ready when the next sample arrives.
  always_ff @(posedge clk) begin
    if (sample_go) begin
      window_store[write_slot] <= sample_value;
    end
    old_sample <= window_store[write_slot_next];
  end

  // Window bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      n100       <= '0;
      sum        <= '0;
      latest     <= '0;
    end else if (sample_go) begin
      write_slot <= write_slot_next;
      sum        <= sum_next;
      latest     <= sample_value;
      if (!full) begin
        fill_count <= fill_count + 1'b1;
        n100       <= n100 + N100_W'(sdw_pkg::PERCENT);
      end
    end
  end

endmodule

### sv/sdw_check.sv
module sdw_check #(
  parameter int WINDOW_SIZE = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       sample_go,
  input  logic                                       tick_go,
  input  logic [sdw_pkg::TIMEOUT_W-1:0]              timeout_ticks,
  input  logic [sdw_pkg::TOLERANCE_W-1:0]            tolerance_percent,
  input  logic signed [sdw_pkg::SAMPLE_W-1:0]        latest,
  input  logic [$clog2(WINDOW_SIZE*100+1)-1:0]       n100,
  input  logic signed [sdw_pkg::SAMPLE_W+$clog2(WINDOW_SIZE)-1:0] sum,
  input  logic                                       empty,
  input  logic                                       b_go,
  output logic                                       b_valid,
  output logic                                       res_valid,
  output sdw_pkg::out_t                              res
);

  localparam int SUM_W  = sdw_pkg::SAMPLE_W + $clog2(WINDOW_SIZE);
  localparam int PROD_W = SUM_W + sdw_pkg::FACTOR_W;

  logic                                offline_flag;
  logic [sdw_pkg::TIMEOUT_W-1:0]       silence_count;
  logic                                timed_out;
  logic                                b_load;
  logic signed [sdw_pkg::FACTOR_W-1:0] hi_factor;
  logic signed [sdw_pkg::FACTOR_W-1:0] lo_factor;
  logic signed [PROD_W-1:0]            lhs_next;
  logic signed [PROD_W-1:0]            hi_next;
  logic signed [PROD_W-1:0]            lo_next;

  // Compare stage registers.
  logic                                b_offline;
  logic signed [sdw_pkg::SAMPLE_W-1:0] b_value;
  logic signed [PROD_W-1:0]            b_lhs;
  logic signed [PROD_W-1:0]            b_hi;
  logic signed [PROD_W-1:0]            b_lo;
  logic                                above;
  logic                                below;

  assign timed_out = (silence_count >= timeout_ticks);

  // An online tick that times out or finds window samples goes on to compare.
  assign b_load = tick_go && !offline_flag && (timed_out || !empty);

  // Band factors; 100 - tol goes negative for tolerances above 100.
  assign hi_factor = sdw_pkg::FACTOR_W'(sdw_pkg::PERCENT)
                   + sdw_pkg::FACTOR_W'(tolerance_percent);
  assign lo_factor = sdw_pkg::FACTOR_W'(sdw_pkg::PERCENT)
                   - sdw_pkg::FACTOR_W'(tolerance_percent);

  // Products from registered state, one multiplier each.
  assign lhs_next = PROD_W'(latest) * PROD_W'($signed({1'b0, n100}));
  assign hi_next  = PROD_W'(sum) * PROD_W'(hi_factor);
  assign lo_next  = PROD_W'(sum) * PROD_W'(lo_factor);

  // Silence counter and offline flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      offline_flag  <= 1'b0;
      silence_count <= '0;
    end else if (sample_go) begin
      offline_flag  <= 1'b0;
      silence_count <= '0;
    end else if (tick_go && !offline_flag) begin
      if (timed_out) begin
        offline_flag  <= 1'b1;
        silence_count <= '0;
      end else begin
        silence_count <= silence_count + 1'b1;
      end
    end
  end

  // Compare stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  // Compare stage payload.
  always_ff @(posedge clk) begin
    if (b_load) begin
      b_offline <= timed_out;
      b_value   <= latest;
      b_lhs     <= lhs_next;
      b_hi      <= hi_next;
      b_lo      <= lo_next;
    end
  end

  // Band check; above takes priority over below.
  assign above = (b_lhs > b_hi);
  assign below = (b_lhs < b_lo);

  assign res_valid = b_valid && (b_offline || above || below);

  always_comb begin
    res.reported_value = b_value;
    if (b_offline) begin
      res.alarm = sdw_pkg::ALARM_OFFLINE;
    end else if (above) begin
      res.alarm = sdw_pkg::ALARM_ABOVE;
    end else begin
      res.alarm = sdw_pkg::ALARM_BELOW;
    end
  end

endmodule
